FILE: hdl/arpc_pkg.sv
package arpc_pkg;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int ENTRY_W = IP_W + MAC_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [IP_W-1:0]  IP_BCAST  = 32'hFFFF_FFFF;
    localparam logic [MAC_W-1:0] MAC_BCAST = {6{8'hFF}};

    // result status codes
    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_UPDATED  = 3'd2;
    localparam logic [2:0] ST_INSERTED = 3'd3;
    localparam logic [2:0] ST_DROPPED  = 3'd4;

    // request kinds
    localparam logic KIND_LEARN   = 1'b0;
    localparam logic KIND_RESOLVE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MY_IP       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP  = 2'd2;

    typedef struct packed {
        logic             kind;
        logic [IP_W-1:0]  ip_addr;
        logic [MAC_W-1:0] mac_addr;
    } arpc_req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             found;
        logic [MAC_W-1:0] mac_out;
        logic [IP_W-1:0]  next_hop;
    } arpc_res_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } arpc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic last;
        logic bcast;
    } arpc_stat_t;

endpackage

FILE: hdl/arp_cache_next_hop_resolver.sv
// ARP cache with next-hop selection.
//
// Request channel: drive request and raise start; the transfer happens at the
// rising edge where start is high and busy is low. kind 0 learns an IP/MAC
// pair (refresh a matching entry, else fill the lowest free slot, else drop);
// kind 1 resolves a destination to a next hop and looks that hop up.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver cannot stall, so each result must be taken in that cycle.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 my_ip, 1 subnet_mask,
// 2 gateway_ip, 3 ignored) and cfg_data. cfg_ready is always high; write only
// while the block is idle.
// Timing: the table sits in a single-port-read RAM and is scanned one entry per
// cycle; a lookup stops at the first hit, a miss or insert scans every entry,
// and a broadcast resolve skips the scan. A new request is taken in the cycle
// done is high; busy stays high from the transfer until then, so only one
// request is in flight at a time.
// Reset: rst_n clears all valid bits at once (no clearing pass), the config
// registers to zero, and returns the controller to idle.
module arp_cache_next_hop_resolver #(
    parameter int ENTRIES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  arpc_pkg::arpc_req_t            request,
    output logic                           done,
    output arpc_pkg::arpc_res_t            result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arpc_pkg::IP_W-1:0]      cfg_data
);
    import arpc_pkg::*;

    arpc_cmd_t  cmd;
    arpc_stat_t stat;

    // config writes never wait
    assign cfg_ready = 1'b1;

    // sequencer: idle -> scan -> finish
    arpc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // table, scan compare, next-hop logic and result register
    arpc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .request   (request),
        .result    (result),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

FILE: hdl/arpc_ram.sv
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hdl/arpc_ctrl.sv
module arpc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output arpc_pkg::arpc_cmd_t cmd,
    input  arpc_pkg::arpc_stat_t stat
);
    import arpc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    done_reg <= 1'b0;
                    if (stat.bcast || stat.hit || stat.last)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign cmd.load   = (state_reg == S_IDLE) && start;
    assign cmd.scan   = (state_reg == S_SCAN);
    assign cmd.commit = (state_reg == S_FINISH);

endmodule

FILE: hdl/arpc_datapath.sv
module arpc_datapath #(
    parameter int ENTRIES = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  arpc_pkg::arpc_cmd_t               cmd,
    output arpc_pkg::arpc_stat_t              stat,
    input  arpc_pkg::arpc_req_t               request,
    output arpc_pkg::arpc_res_t               result,
    input  logic                              cfg_valid,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arpc_pkg::IP_W-1:0]         cfg_data
);
    import arpc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // configuration
    logic [IP_W-1:0] my_ip_reg, mask_reg, gateway_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_ip_reg   <= '0;
            mask_reg    <= '0;
            gateway_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MY_IP:       my_ip_reg   <= cfg_data;
                CFG_SUBNET_MASK: mask_reg    <= cfg_data;
                CFG_GATEWAY_IP:  gateway_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // next-hop choice at request time
    logic [IP_W-1:0] hop;
    always_comb
    begin
        if (request.ip_addr == IP_BCAST ||
            (request.ip_addr & mask_reg) == (my_ip_reg & mask_reg))
        begin
            hop = request.ip_addr;
        end
        else
        begin
            hop = gateway_reg;
        end
    end

    // request registers
    logic             kind_reg;
    logic [IP_W-1:0]  key_reg;
    logic [MAC_W-1:0] mac_reg;

    // scan state
    logic [IDX_W-1:0] addr_reg, cmp_idx_reg;
    logic             pend_reg;
    logic             hit_reg, free_reg;
    logic [IDX_W-1:0] hit_idx_reg, free_idx_reg;
    logic [MAC_W-1:0] hit_mac_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic [ENTRY_W-1:0] rd_data;
    logic               cmp_on, match, slot_valid;

    assign slot_valid = valid_reg[cmp_idx_reg];
    assign cmp_on     = cmd.scan && pend_reg;
    assign match      = cmp_on && slot_valid && (rd_data[ENTRY_W-1:MAC_W] == key_reg);

    assign stat.hit   = match;
    assign stat.last  = pend_reg && (cmp_idx_reg == LAST_IDX);
    assign stat.bcast = (kind_reg == KIND_RESOLVE) && (key_reg == IP_BCAST);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= request.kind;
            key_reg  <= (request.kind == KIND_RESOLVE) ? hop : request.ip_addr;
            mac_reg  <= request.mac_addr;
        end
        if (cmd.scan)
        begin
            cmp_idx_reg <= addr_reg;
        end
        if (match)
        begin
            hit_idx_reg <= cmp_idx_reg;
            hit_mac_reg <= rd_data[MAC_W-1:0];
        end
        if (cmp_on && !slot_valid && !free_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            pend_reg <= 1'b0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            addr_reg <= '0;
            pend_reg <= 1'b0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            addr_reg <= addr_reg + 1'b1;
            pend_reg <= 1'b1;
            if (match)
            begin
                hit_reg <= 1'b1;
            end
            if (cmp_on && !slot_valid)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    // table write on learn
    logic             we;
    logic [IDX_W-1:0] wr_addr;

    assign we      = cmd.commit && (kind_reg == KIND_LEARN) && (hit_reg || free_reg);
    assign wr_addr = hit_reg ? hit_idx_reg : free_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data ({key_reg, mac_reg}),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // result register
    arpc_res_t res_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (kind_reg == KIND_LEARN)
            begin
                res_reg.found    <= 1'b0;
                res_reg.mac_out  <= '0;
                res_reg.next_hop <= '0;
                if (hit_reg)
                begin
                    res_reg.status <= ST_UPDATED;
                end
                else if (free_reg)
                begin
                    res_reg.status <= ST_INSERTED;
                end
                else
                begin
                    res_reg.status <= ST_DROPPED;
                end
            end
            else
            begin
                res_reg.next_hop <= key_reg;
                if (stat.bcast)
                begin
                    res_reg.status  <= ST_HIT;
                    res_reg.found   <= 1'b1;
                    res_reg.mac_out <= MAC_BCAST;
                end
                else if (hit_reg)
                begin
                    res_reg.status  <= ST_HIT;
                    res_reg.found   <= 1'b1;
                    res_reg.mac_out <= hit_mac_reg;
                end
                else
                begin
                    res_reg.status  <= ST_MISS;
                    res_reg.found   <= 1'b0;
                    res_reg.mac_out <= '0;
                end
            end
        end
    end

    assign result = res_reg;

endmodule
